// ===== rtl/dimu_pkg.sv =====
// Shared types and constants of the dual IMU sample combiner.
package dimu_pkg;

    // Transaction operation codes
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_READ   = 2'd2
    } opcode_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL = 2'd1;

    localparam logic [31:0] INTERVAL_RESET = 32'd2350;

    // One stored slot: six averaged axes
    typedef struct packed {
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } slot_t;

endpackage

// ===== rtl/dimu_axis_avg.sv =====
// Axis sign correction and pairwise averaging of two raw IMU readings.
module dimu_axis_avg
    import dimu_pkg::*;
(
    input  logic [47:0] a_gyro,
    input  logic [47:0] a_accel,
    input  logic [47:0] b_gyro,
    input  logic [47:0] b_accel,
    output slot_t       avg
);

    // Average with truncation toward zero: add one to a negative sum, then halve
    function automatic logic signed [15:0] avg16(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
        logic signed [16:0] s;
        s = {a[15], a} + {b[15], b};
        s = s + {16'b0, s[16]};
        return s[16:1];
    endfunction

    logic signed [15:0] agx, agy, agz, aax, aay, aaz;
    logic signed [15:0] bgx, bgy, bgz, bax, bay, baz;

    // Unpack little-endian axes; negate A X and B Y (16-bit wrap keeps -32768)
    always_comb
    begin
        agx = -$signed(a_gyro[15:0]);
        agy = $signed(a_gyro[31:16]);
        agz = $signed(a_gyro[47:32]);
        aax = -$signed(a_accel[15:0]);
        aay = $signed(a_accel[31:16]);
        aaz = $signed(a_accel[47:32]);
        bgx = $signed(b_gyro[15:0]);
        bgy = -$signed(b_gyro[31:16]);
        bgz = $signed(b_gyro[47:32]);
        bax = $signed(b_accel[15:0]);
        bay = -$signed(b_accel[31:16]);
        baz = $signed(b_accel[47:32]);
    end

    // Average each axis pair
    always_comb
    begin
        avg.gyro_x  = avg16(agx, bgx);
        avg.gyro_y  = avg16(agy, bgy);
        avg.gyro_z  = avg16(agz, bgz);
        avg.accel_x = avg16(aax, bax);
        avg.accel_y = avg16(aay, bay);
        avg.accel_z = avg16(aaz, baz);
    end

endmodule

// ===== rtl/dual_imu_sample_combiner.sv =====
// Top level of the dual IMU sample combiner.
//
// Input channel (in_valid/in_ready) carries one transaction per item: an
// opcode, a timestamp and the raw gyro and accel bytes of sensors A and B.
// A sample transaction is stored into the next free slot when enabled, when
// a slot is free and when the timestamp has moved on by more than the
// interval. A clear transaction empties the slot count; a read transaction
// returns SLOT_COUNT result transactions on the output channel, one per slot,
// with last set on the final one.
// Configuration (cfg_valid/cfg_ready, always ready) writes enable and the
// interval; write only while the block is idle.
// Timing: an item is registered into the processing stage on acceptance; a sample
// or clear item is finished in the next cycle, and such items sustain one per cycle.
// A read item occupies the processing stage until its last slot is loaded, one slot
// per cycle through the single output register; its first result passes the stage
// register and the output register. When the receiver stalls, the output register
// holds its result, the read pauses and the input channel stops once the stage is blocked.
// Reset clears the slot store to zero, the slot count and the last taken
// time, disables sampling and loads the default interval of 2350.
module dual_imu_sample_combiner
    import dimu_pkg::*;
#(
    parameter int SLOT_COUNT = 3
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data,
    // input channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             opcode,
    input  logic [31:0]            timestamp,
    input  logic [47:0]            sensor_a_gyro,
    input  logic [47:0]            sensor_a_accel,
    input  logic [47:0]            sensor_b_gyro,
    input  logic [47:0]            sensor_b_accel,
    // output channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             slot,
    output logic signed [15:0]     gyro_x,
    output logic signed [15:0]     gyro_y,
    output logic signed [15:0]     gyro_z,
    output logic signed [15:0]     accel_x,
    output logic signed [15:0]     accel_y,
    output logic signed [15:0]     accel_z,
    output logic                   last
);

    localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int FILL_W = $clog2(SLOT_COUNT + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(SLOT_COUNT);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(SLOT_COUNT - 1);

    // configuration registers
    logic        enable_reg;
    logic [31:0] interval_reg;

    // processing stage
    logic        stage_valid_reg;
    logic [1:0]  stage_op_reg;
    logic [31:0] stage_ts_reg;
    logic [47:0] stage_ag_reg, stage_aa_reg, stage_bg_reg, stage_ba_reg;

    // block state
    logic [31:0]       taken_ts_reg;
    logic [FILL_W-1:0] filled_reg;
    slot_t             store_reg [SLOT_COUNT];
    logic [IDX_W-1:0]  rd_idx_reg;

    // output register
    logic              out_valid_reg;
    logic [1:0]        slot_reg;
    slot_t             data_reg;
    logic              last_reg;

    logic              out_load;
    logic              stage_done;
    logic              take_sample;
    logic              time_ok;
    logic [31:0]       fwd_diff;
    logic [31:0]       wrap_diff;
    logic [IDX_W+1:0]  rd_idx_ext;
    slot_t             avg;

    dimu_axis_avg u_avg (
        .a_gyro  (stage_ag_reg),
        .a_accel (stage_aa_reg),
        .b_gyro  (stage_bg_reg),
        .b_accel (stage_ba_reg),
        .avg     (avg)
    );

    // Time gate: forward distance, or distance across the counter wrap
    always_comb
    begin
        fwd_diff  = stage_ts_reg - taken_ts_reg;
        wrap_diff = fwd_diff - 32'd1;
        time_ok   = ((stage_ts_reg > taken_ts_reg) && (fwd_diff > interval_reg))
                 || ((stage_ts_reg < taken_ts_reg) && (wrap_diff > interval_reg));
    end

    // Stage completion and handshakes
    always_comb
    begin
        out_load    = !out_valid_reg || out_ready;
        take_sample = stage_valid_reg && (stage_op_reg == OP_SAMPLE) && enable_reg
                   && (filled_reg < FILL_FULL) && time_ok;
        unique case (stage_op_reg)
            OP_READ:   stage_done = out_load && (rd_idx_reg == IDX_LAST);
            OP_SAMPLE: stage_done = 1'b1;
            OP_CLEAR:  stage_done = 1'b1;
            default:   stage_done = 1'b1;
        endcase
        in_ready   = !stage_valid_reg || stage_done;
        cfg_ready  = 1'b1;
        rd_idx_ext = {2'b00, rd_idx_reg};
    end

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            interval_reg <= INTERVAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_ENABLE)
                enable_reg <= cfg_data[0];
            if (cfg_index == CFG_INTERVAL)
                interval_reg <= cfg_data;
        end
    end

    // Capture the input transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (in_ready)
            stage_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_op_reg <= opcode;
            stage_ts_reg <= timestamp;
            stage_ag_reg <= sensor_a_gyro;
            stage_aa_reg <= sensor_a_accel;
            stage_bg_reg <= sensor_b_gyro;
            stage_ba_reg <= sensor_b_accel;
        end
    end

    // Update slot count, last time and slot store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_ts_reg <= '0;
            filled_reg   <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
                store_reg[i] <= '0;
        end
        else if (take_sample)
        begin
            taken_ts_reg <= stage_ts_reg;
            filled_reg   <= filled_reg + FILL_W'(1);
            store_reg[filled_reg[IDX_W-1:0]] <= avg;
        end
        else if (stage_valid_reg && (stage_op_reg == OP_CLEAR))
            filled_reg <= '0;
    end

    // Advance the read-out slot index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_idx_reg <= '0;
        else if (stage_valid_reg && (stage_op_reg == OP_READ) && out_load)
        begin
            if (rd_idx_reg == IDX_LAST)
                rd_idx_reg <= '0;
            else
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
        end
    end

    // Load the output register with the current slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= stage_valid_reg && (stage_op_reg == OP_READ);
    end

    always_ff @(posedge clk)
    begin
        if (out_load && stage_valid_reg && (stage_op_reg == OP_READ))
        begin
            slot_reg <= rd_idx_ext[1:0];
            data_reg <= store_reg[rd_idx_reg];
            last_reg <= (rd_idx_reg == IDX_LAST);
        end
    end

    assign out_valid = out_valid_reg;
    assign slot      = slot_reg;
    assign gyro_x    = data_reg.gyro_x;
    assign gyro_y    = data_reg.gyro_y;
    assign gyro_z    = data_reg.gyro_z;
    assign accel_x   = data_reg.accel_x;
    assign accel_y   = data_reg.accel_y;
    assign accel_z   = data_reg.accel_z;
    assign last      = last_reg;

    // Slot count never passes the number of slots
    assert property (@(posedge clk) disable iff (!rst_n) filled_reg <= FILL_FULL)
        else $error("slot count beyond slot store");

    // A read-out in progress belongs to a read transaction in the stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd_idx_reg != '0) |-> (stage_valid_reg && (stage_op_reg == OP_READ)))
        else $error("read index moved without a read transaction");

    // A stalled output freezes the read-out position
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(rd_idx_reg))
        else $error("read index advanced during output stall");

    // An unfinished read blocks new input
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && (stage_op_reg == OP_READ) && (rd_idx_reg != IDX_LAST))
            |-> !in_ready)
        else $error("input accepted while read-out pending");

endmodule

// ===== sim/dual_imu_sample_combiner_test.sv =====
// Self-checking testbench for the dual IMU sample combiner: directed and random transactions.
module dual_imu_sample_combiner_test;
    import dimu_pkg::*;

    localparam int SLOTS           = 3;
    localparam int ITEM_TARGET     = 370;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One slot as it leaves the block on a read-out
    typedef struct packed {
        logic [1:0] idx;
        slot_t      axes;
        logic       fin;
    } slot_readout_t;

    // Mirror of the slot store; queues the read-outs each read transaction must produce
    class slot_scoreboard;
        bit            enabled;
        logic [31:0]   interval;
        logic [31:0]   taken_ts;
        int            filled;
        slot_t         store [SLOTS];
        slot_readout_t readouts [$];
        int            fail_count;
        int            checked;
        int            stored;

        function new();
            enabled   = 1'b0;
            interval  = INTERVAL_RESET;
            taken_ts  = '0;
            filled    = 0;
            foreach (store[i]) store[i] = '0;
            fail_count = 0;
            checked    = 0;
            stored     = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
            if (idx == CFG_ENABLE)
                enabled = data[0];
            else if (idx == CFG_INTERVAL)
                interval = data;
        endfunction

        function int outstanding();
            return readouts.size();
        endfunction

        function int lane(logic [47:0] raw, int k);
            logic signed [15:0] v;
            v = raw[16*k +: 16];
            return int'(v);
        endfunction

        // Negating the most negative value wraps back onto itself
        function int flip(int v);
            return (v == -32768) ? v : -v;
        endfunction

        // Signed int division already truncates toward zero
        function logic signed [15:0] mean(int a, int b);
            int s;
            s = a + b;
            return 16'(s / 2);
        endfunction

        // Advance the last taken time only when the sample is due
        function bit stamp_due(logic [31:0] ts);
            logic [31:0] span;
            if (ts < taken_ts)
                span = 32'hFFFF_FFFF - taken_ts + ts;
            else if (ts > taken_ts)
                span = ts - taken_ts;
            else
                return 1'b0;
            if (span > interval)
            begin
                taken_ts = ts;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_item(logic [1:0] op, logic [31:0] ts, logic [47:0] ag,
                                logic [47:0] aa, logic [47:0] bg, logic [47:0] ba);
            slot_readout_t r;
            case (op)
                OP_SAMPLE:
                begin
                    if (enabled && filled < SLOTS && stamp_due(ts))
                    begin
                        store[filled].gyro_x  = mean(flip(lane(ag, 0)), lane(bg, 0));
                        store[filled].gyro_y  = mean(lane(ag, 1), flip(lane(bg, 1)));
                        store[filled].gyro_z  = mean(lane(ag, 2), lane(bg, 2));
                        store[filled].accel_x = mean(flip(lane(aa, 0)), lane(ba, 0));
                        store[filled].accel_y = mean(lane(aa, 1), flip(lane(ba, 1)));
                        store[filled].accel_z = mean(lane(aa, 2), lane(ba, 2));
                        filled++;
                        stored++;
                    end
                end
                OP_CLEAR:
                    filled = 0;
                OP_READ:
                begin
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        r.idx  = 2'(s);
                        r.axes = store[s];
                        r.fin  = (s == SLOTS - 1);
                        readouts.push_back(r);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(slot_readout_t got);
            slot_readout_t want;
            int            w [8];
            int            g [8];
            string         tag [8] = '{"slot", "gyro_x", "gyro_y", "gyro_z",
                                       "accel_x", "accel_y", "accel_z", "last"};
            if (readouts.size() == 0)
            begin
                $display("%0t: unexpected read-out transaction, slot %0d", $time, got.idx);
                fail_count++;
                return;
            end
            want = readouts.pop_front();
            checked++;
            w = '{int'(want.idx), int'(want.axes.gyro_x), int'(want.axes.gyro_y),
                  int'(want.axes.gyro_z), int'(want.axes.accel_x), int'(want.axes.accel_y),
                  int'(want.axes.accel_z), int'(want.fin)};
            g = '{int'(got.idx), int'(got.axes.gyro_x), int'(got.axes.gyro_y),
                  int'(got.axes.gyro_z), int'(got.axes.accel_x), int'(got.axes.accel_y),
                  int'(got.axes.accel_z), int'(got.fin)};
            for (int i = 0; i < 8; i++)
            begin
                if (w[i] != g[i])
                begin
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, tag[i], w[i], g[i]);
                    fail_count++;
                end
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [1:0]             opcode;
    logic [31:0]            timestamp;
    logic [47:0]            sensor_a_gyro;
    logic [47:0]            sensor_a_accel;
    logic [47:0]            sensor_b_gyro;
    logic [47:0]            sensor_b_accel;
    logic                   out_valid;
    logic                   out_ready;
    logic [1:0]             slot;
    logic signed [15:0]     gyro_x;
    logic signed [15:0]     gyro_y;
    logic signed [15:0]     gyro_z;
    logic signed [15:0]     accel_x;
    logic signed [15:0]     accel_y;
    logic signed [15:0]     accel_z;
    logic                   last;

    slot_scoreboard sb;
    int             cycle_count;
    int             items_sent;
    int             settings_used;
    int             hold_offs_done;
    bit             tx_steady;
    bit             rx_steady;
    bit             hold_off_req;

    dual_imu_sample_combiner #(.SLOT_COUNT(SLOTS)) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .timestamp      (timestamp),
        .sensor_a_gyro  (sensor_a_gyro),
        .sensor_a_accel (sensor_a_accel),
        .sensor_b_gyro  (sensor_b_gyro),
        .sensor_b_accel (sensor_b_accel),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .slot           (slot),
        .gyro_x         (gyro_x),
        .gyro_y         (gyro_y),
        .gyro_z         (gyro_z),
        .accel_x        (accel_x),
        .accel_y        (accel_y),
        .accel_z        (accel_z),
        .last           (last)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stop a hung run
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Check every accepted read-out transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(slot_readout_t'({slot, gyro_x, gyro_y, gyro_z,
                                             accel_x, accel_y, accel_z, last}));
    end

    // Receiver: random stalls, steady stretches, and one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
                hold_offs_done++;
            end
            else if (rx_steady)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    out_ready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
                else if (r < 92)
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                end
            end
        end
    end

    function automatic int sender_gap();
        int r;
        if (tx_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Mostly random lanes, with the corner values mixed in often
    function automatic logic [47:0] rand_axes();
        logic [47:0] v;
        for (int k = 0; k < 3; k++)
        begin
            case ($urandom_range(0, 9))
                0:       v[16*k +: 16] = 16'h8000;
                1:       v[16*k +: 16] = 16'h7FFF;
                2:       v[16*k +: 16] = 16'hFFFF;
                3:       v[16*k +: 16] = 16'h0000;
                4:       v[16*k +: 16] = 16'h0001;
                default: v[16*k +: 16] = 16'($urandom);
            endcase
        end
        return v;
    endfunction

    // Pick a timestamp around the acceptance threshold of the next sample
    function automatic logic [31:0] next_stamp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return sb.taken_ts + sb.interval + 32'd1 + 32'($urandom_range(0, 7));
        if (r < 80)
            return sb.taken_ts + sb.interval;
        if (r < 90)
            return sb.taken_ts + 32'($urandom_range(0, sb.interval));
        return 32'($urandom);
    endfunction

    // Drive one input transaction and hold it until accepted
    task automatic send_item(input logic [1:0] op, input logic [31:0] ts,
                             input logic [47:0] ag, input logic [47:0] aa,
                             input logic [47:0] bg, input logic [47:0] ba);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        opcode         <= op;
        timestamp      <= ts;
        sensor_a_gyro  <= ag;
        sensor_a_accel <= aa;
        sensor_b_gyro  <= bg;
        sensor_b_accel <= ba;
        do @(posedge clk); while (!in_ready);
        sb.note_item(op, ts, ag, aa, bg, ba);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic send_op(input logic [1:0] op);
        send_item(op, 32'($urandom), rand_axes(), rand_axes(), rand_axes(), rand_axes());
    endtask

    task automatic send_sample(input logic [31:0] ts, input logic [47:0] ag,
                               input logic [47:0] aa, input logic [47:0] bg,
                               input logic [47:0] ba);
        send_item(OP_SAMPLE, ts, ag, aa, bg, ba);
    endtask

    // Drain all expected read-outs, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back; upper bits of the enable word are don't-care
    task automatic configure(input logic en, input logic [31:0] iv);
        logic [31:0] en_word;
        en_word   = {31'($urandom), en};
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ENABLE;
        cfg_data  <= en_word;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(CFG_ENABLE, en_word);
        cfg_index <= CFG_INTERVAL;
        cfg_data  <= iv;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(CFG_INTERVAL, iv);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        int          phase_idx;
        int          phase_end;
        int          samples;
        logic        en;
        logic [31:0] iv;

        sb             = new();
        items_sent     = 0;
        settings_used  = 0;
        hold_offs_done = 0;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        hold_off_req   = 1'b0;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_ENABLE;
        cfg_data       = '0;
        in_valid       = 1'b0;
        opcode         = OP_SAMPLE;
        timestamp      = '0;
        sensor_a_gyro  = '0;
        sensor_a_accel = '0;
        sensor_b_gyro  = '0;
        sensor_b_accel = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state: store reads as zero, sampling is disabled
        send_op(OP_READ);
        send_sample(32'd5000, {3{16'h1234}}, {3{16'h8000}}, {3{16'h7FFF}}, {3{16'hFFFF}});
        send_op(OP_READ);

        // Zero interval: equal stamps rejected, corner lanes, overfill dropped
        wait_idle();
        configure(1'b1, 32'd0);
        send_sample(32'd0, {3{16'h4000}}, {3{16'h4000}}, {3{16'h4000}}, {3{16'h4000}});
        send_sample(32'd1, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        send_sample(32'd2, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        send_sample(32'd2, {3{16'h0100}}, {3{16'h0100}}, {3{16'h0100}}, {3{16'h0100}});
        send_sample(32'd3, {3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'h0001}}, {3{16'h0001}});
        send_sample(32'd4, {3{16'h2222}}, {3{16'h2222}}, {3{16'h2222}}, {3{16'h2222}});
        send_op(OP_READ);
        send_op(OP_CLEAR);
        send_op(OP_UNUSED);

        // Timestamp wrap past all ones
        send_sample(32'hFFFF_FFF0, {16'h0003, 16'hFFFD, 16'h0001}, {16'h8000, 16'h7FFF, 16'h0000},
                    {16'hFFFE, 16'h0002, 16'h8000}, {16'h7FFF, 16'h8000, 16'hFFFF});
        send_sample(32'd5, {16'h8001, 16'h0001, 16'hFFFF}, {16'h0002, 16'hFFFE, 16'h7FFE},
                    {16'h0001, 16'h7FFF, 16'h8000}, {16'hFFFF, 16'h0001, 16'h8001});
        send_sample(32'd5, {3{16'h5555}}, {3{16'hAAAA}}, {3{16'h5555}}, {3{16'hAAAA}});
        send_op(OP_READ);

        // Maximum interval: nothing can ever be due
        wait_idle();
        configure(1'b1, 32'hFFFF_FFFF);
        send_sample(32'd4, rand_axes(), rand_axes(), rand_axes(), rand_axes());
        send_sample(32'hFFFF_FFFF, rand_axes(), rand_axes(), rand_axes(), rand_axes());
        send_op(OP_READ);
        send_op(OP_CLEAR);

        // Default interval: exactly the interval is too soon, one more is due
        wait_idle();
        configure(1'b0, INTERVAL_RESET);
        configure(1'b1, INTERVAL_RESET);
        send_sample(sb.taken_ts + INTERVAL_RESET, rand_axes(), rand_axes(), rand_axes(),
                    rand_axes());
        send_sample(sb.taken_ts + INTERVAL_RESET + 32'd1, rand_axes(), rand_axes(),
                    rand_axes(), rand_axes());
        send_op(OP_READ);

        // Random phases, each under a fresh register setting
        phase_idx = 0;
        while (items_sent < ITEM_TARGET)
        begin
            wait_idle();
            en = ($urandom_range(0, 99) < 85);
            case ($urandom_range(0, 6))
                0:       iv = 32'd0;
                1:       iv = 32'd1;
                2:       iv = INTERVAL_RESET;
                3:       iv = 32'($urandom_range(1, 5000));
                4:       iv = 32'hFFFF_FFFF;
                5:       iv = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
                default: iv = 32'($urandom);
            endcase
            configure(en, iv);
            tx_steady = (phase_idx % 4 == 2) || (phase_idx == 1);
            rx_steady = (phase_idx % 4 == 2);
            // Stall the output while the sender keeps pushing
            if (phase_idx == 1)
                hold_off_req = 1'b1;
            phase_end = items_sent + $urandom_range(30, 60);
            while (items_sent < phase_end && items_sent < ITEM_TARGET)
            begin
                if ($urandom_range(0, 99) < 70)
                begin
                    samples = $urandom_range(1, 4);
                    repeat (samples)
                        send_sample(next_stamp(), rand_axes(), rand_axes(), rand_axes(),
                                    rand_axes());
                    send_op(OP_READ);
                    if ($urandom_range(0, 1) == 1)
                        send_op(OP_CLEAR);
                end
                else
                    send_op(2'($urandom_range(0, 3)));
            end
            phase_idx++;
        end

        wait_idle();
        tx_steady = 1'b0;
        $display("Ran %0d transactions under %0d register settings with %0d long hold-off(s).",
                 items_sent, settings_used, hold_offs_done);
        $display("Stored %0d samples and checked %0d slot read-outs.", sb.stored, sb.checked);
        if (sb.fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
